/* hdl/dpfa_pkg.sv */
package dpfa_pkg;

  localparam int ExpW  = 11;
  localparam int FracW = 52;
  localparam int EW    = 14;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_code_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SPECIAL, OP_NORM, OP_ALIGN, OP_ADDSUM,
    OP_MULINIT, OP_MUL, OP_MULFIN, OP_DIVINIT, OP_DIV, OP_DIVFIN,
    OP_PRE, OP_RNORM, OP_DENORM, OP_FIN
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_NORM, S_ALIGN, S_ADDSUM, S_MULINIT, S_MUL, S_MULFIN,
    S_DIVINIT, S_DIV, S_DIVFIN, S_PRE, S_RNORM, S_DENORM, S_FIN, S_DONE
  } state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_ctrl_t;

  typedef struct packed {
    cmd_code_t opc;
    logic      special;
    logic      norm_done;
    logic      sum_zero;
    logic      sig62;
    logic      mul_last;
    logic      div_last;
  } dp_stat_t;

endpackage

/* hdl/dpfa_datapath.sv */
module dpfa_datapath
  import dpfa_pkg::*;
(
  input  logic        clk,
  input  dp_ctrl_t    ctrl,
  output dp_stat_t    stat,
  input  logic [1:0]  command,
  input  logic [63:0] operand_a,
  input  logic [63:0] operand_b,
  output logic [63:0] result
);

  localparam logic [63:0] ExpMask = {1'b0, {ExpW{1'b1}}, {FracW{1'b0}}};

  cmd_code_t            opc;
  logic [63:0]          a, b;
  logic [52:0]          ma, mb;
  logic signed [EW-1:0] ka, kb, e2, ee;
  logic                 sgn, ys;
  logic [63:0]          x, y, sig, res, pp;
  logic [54:0]          r;
  logic [62:0]          q;
  logic [5:0]           cnt;
  logic [127:0]         acc;
  logic [1:0]           ppsh;

  function automatic logic is_nan(input logic [63:0] v);
    return (v[62:52] == '1) && (v[51:0] != '0);
  endfunction
  function automatic logic is_inf(input logic [63:0] v);
    return (v[62:52] == '1) && (v[51:0] == '0);
  endfunction
  function automatic logic is_zero(input logic [63:0] v);
    return v[62:0] == '0;
  endfunction

  // special-value decode: flag in bit 64, value below
  function automatic logic [64:0] special(input cmd_code_t c, input logic [63:0] va,
                                          input logic [63:0] vb);
    logic [63:0] s;
    logic [63:0] cn0;
    s   = {va[63] ^ vb[63], 63'd0};
    cn0 = ExpMask | 64'd1;
    case (c)
      CMD_ADD, CMD_SUB: begin
        if (is_nan(va)) return {1'b1, va};
        else if (is_nan(vb)) return {1'b1, vb};
        else if (is_inf(va)) return {1'b1, (is_inf(vb) && va[63] != vb[63]) ? cn0 : va};
        else if (is_inf(vb)) return {1'b1, vb};
        else if (is_zero(va) && is_zero(vb)) return {1'b1, va[63] & vb[63], 63'd0};
        else if (is_zero(va)) return {1'b1, vb};
        else if (is_zero(vb)) return {1'b1, va};
        else return {1'b0, 64'd0};
      end
      CMD_MUL: begin
        if (is_nan(va)) return {1'b1, va};
        else if (is_nan(vb)) return {1'b1, vb};
        else if (is_inf(va)) return {1'b1, is_zero(vb) ? (s | cn0) : (s | ExpMask)};
        else if (is_inf(vb)) return {1'b1, is_zero(va) ? (s | cn0) : (s | ExpMask)};
        else if (is_zero(va) || is_zero(vb)) return {1'b1, s};
        else return {1'b0, 64'd0};
      end
      default: begin
        if (is_nan(va) || is_nan(vb)) return {1'b1, s | cn0};
        else if (is_zero(vb)) return {1'b1, is_zero(va) ? (s | cn0) : (s | ExpMask)};
        else if (is_inf(vb)) return {1'b1, is_inf(va) ? (s | cn0) : s};
        else if (is_inf(va)) return {1'b1, s | ExpMask};
        else if (is_zero(va)) return {1'b1, s};
        else return {1'b0, 64'd0};
      end
    endcase
  endfunction

  logic [64:0]          spec;
  logic                 swap;
  logic [52:0]          xm, ym;
  logic signed [EW-1:0] xk, yk, dd, e_new, sh;
  logic [63:0]          yb, ysh, sum, sd;
  logic [54:0]          rsub;
  logic                 ge;
  logic [31:0]          mop_a, mop_b;
  logic [63:0]          bflip;

  always_comb begin
    spec  = special(opc, a, b);
    swap  = kb > ka;
    xm    = swap ? mb : ma;
    ym    = swap ? ma : mb;
    xk    = swap ? kb : ka;
    yk    = swap ? ka : kb;
    dd    = xk - yk;
    yb    = {1'b0, ym, 10'd0};
    ysh   = yb >> dd[5:0];
    if (dd >= EW'(63)) ysh = 64'd1;
    else if (dd > EW'(0)) ysh = ysh | {63'd0, (yb & ~(64'hFFFF_FFFF_FFFF_FFFF << dd[5:0])) != '0};
    else ysh = yb;
    if (sgn == ys) sum = x + y;
    else if (x >= y) sum = x - y;
    else sum = y - x;
    ge    = r >= {2'b00, mb};
    rsub  = ge ? (r - {2'b00, mb}) : r;
    mop_a = cnt[1] ? {11'd0, ma[52:32]} : ma[31:0];
    mop_b = cnt[0] ? {11'd0, mb[52:32]} : mb[31:0];
    e_new = e2 + EW'(1085);
    sh    = EW'(1) - e_new;
    sd    = sig >> sh[5:0];
    sd    = sd | {63'd0, (sig & ~(64'hFFFF_FFFF_FFFF_FFFF << sh[5:0])) != '0};
    bflip = (cmd_code_t'(command) == CMD_SUB) ? {~operand_b[63], operand_b[62:0]} : operand_b;
  end

  logic [53:0] m;
  logic [9:0]  rem;
  logic        rup;
  logic [63:0] packed_v;
  always_comb begin
    m   = {1'b0, sig[62:10]};
    rem = sig[9:0];
    rup = (rem > 10'h200) || (rem == 10'h200 && m[0]);
    m   = m + {53'd0, rup};
    if (ee <= EW'(0)) packed_v = {sgn, 9'd0, m};
    else packed_v = {sgn, 63'd0} | ({ee[10:0] - 11'd1, 52'd0} + {10'd0, m});
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        opc <= cmd_code_t'(command);
        a   <= operand_a;
        b   <= bflip;
        if (operand_a[62:52] == '0) begin
          ma <= {1'b0, operand_a[51:0]}; ka <= -EW'(1074);
        end else begin
          ma <= {1'b1, operand_a[51:0]}; ka <= EW'({3'd0, operand_a[62:52]}) - EW'(1075);
        end
        if (bflip[62:52] == '0) begin
          mb <= {1'b0, bflip[51:0]}; kb <= -EW'(1074);
        end else begin
          mb <= {1'b1, bflip[51:0]}; kb <= EW'({3'd0, bflip[62:52]}) - EW'(1075);
        end
      end
      OP_SPECIAL: res <= spec[63:0];
      OP_NORM: begin
        if (!ma[52]) begin ma <= ma << 1; ka <= ka - EW'(1); end
        if (!mb[52]) begin mb <= mb << 1; kb <= kb - EW'(1); end
      end
      OP_ALIGN: begin
        x   <= {1'b0, xm, 10'd0};
        y   <= ysh;
        e2  <= xk - EW'(10);
        sgn <= swap ? b[63] : a[63];
        ys  <= swap ? a[63] : b[63];
      end
      OP_ADDSUM: begin
        sig <= sum;
        if (sgn != ys && x < y) sgn <= ys;
        if (sum == '0) res <= 64'd0;
      end
      OP_MULINIT: begin
        acc <= '0; cnt <= '0; sgn <= a[63] ^ b[63];
      end
      OP_MUL: begin
        if (cnt < 6'd4) begin
          pp   <= mop_a * mop_b;
          ppsh <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
        end
        if (cnt != 6'd0) acc <= acc + ({64'd0, pp} << {ppsh, 5'd0});
        cnt <= cnt + 6'd1;
      end
      OP_MULFIN: begin
        sig <= {acc[105:43], acc[42] | (acc[41:0] != '0)};
        e2  <= ka + kb + EW'(42);
      end
      OP_DIVINIT: begin
        r <= {2'b00, ma}; q <= '0; cnt <= '0; sgn <= a[63] ^ b[63];
      end
      OP_DIV: begin
        q   <= {q[61:0], ge};
        r   <= {rsub[53:0], 1'b0};
        cnt <= cnt + 6'd1;
      end
      OP_DIVFIN: begin
        sig <= {1'b0, q[62:1], q[0] | (r != '0)};
        e2  <= ka - kb - EW'(62);
      end
      OP_PRE: if (sig[63]) begin
        sig <= {1'b0, sig[63:2], sig[1] | sig[0]};
        e2  <= e2 + EW'(1);
      end
      OP_RNORM: if (!sig[62]) begin
        sig <= sig << 1;
        e2  <= e2 - EW'(1);
      end
      OP_DENORM: begin
        ee <= e_new;
        if (e_new <= EW'(0)) sig <= (sh >= EW'(63)) ? 64'd1 : sd;
      end
      OP_FIN: res <= (ee >= EW'(2047)) ? ({sgn, 63'd0} | ExpMask) : packed_v;
      default: ;
    endcase
  end

  always_comb begin
    stat.opc       = opc;
    stat.special   = spec[64];
    stat.norm_done = ma[52] & mb[52];
    stat.sum_zero  = sum == '0;
    stat.sig62     = sig[62];
    stat.mul_last  = cnt == 6'd4;
    stat.div_last  = cnt == 6'd62;
  end

  assign result = res;

endmodule

/* hdl/dpfa_ctrl.sv */
module dpfa_ctrl
  import dpfa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_ctrl_t ctrl,
  output logic     busy,
  output logic     done
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    ctrl.op    = OP_NONE;
    case (state)
      S_IDLE: if (start) begin
        ctrl.op = OP_LOAD; state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.special) begin
          ctrl.op = OP_SPECIAL; state_next = S_DONE;
        end else state_next = S_NORM;
      end
      S_NORM: begin
        ctrl.op = OP_NORM;
        if (stat.norm_done) begin
          case (stat.opc)
            CMD_MUL: state_next = S_MULINIT;
            CMD_DIV: state_next = S_DIVINIT;
            default: state_next = S_ALIGN;
          endcase
        end
      end
      S_ALIGN: begin ctrl.op = OP_ALIGN; state_next = S_ADDSUM; end
      S_ADDSUM: begin
        ctrl.op = OP_ADDSUM;
        state_next = stat.sum_zero ? S_DONE : S_PRE;
      end
      S_MULINIT: begin ctrl.op = OP_MULINIT; state_next = S_MUL; end
      S_MUL: begin
        ctrl.op = OP_MUL;
        if (stat.mul_last) state_next = S_MULFIN;
      end
      S_MULFIN: begin ctrl.op = OP_MULFIN; state_next = S_PRE; end
      S_DIVINIT: begin ctrl.op = OP_DIVINIT; state_next = S_DIV; end
      S_DIV: begin
        ctrl.op = OP_DIV;
        if (stat.div_last) state_next = S_DIVFIN;
      end
      S_DIVFIN: begin ctrl.op = OP_DIVFIN; state_next = S_PRE; end
      S_PRE: begin ctrl.op = OP_PRE; state_next = S_RNORM; end
      S_RNORM: begin
        ctrl.op = OP_RNORM;
        if (stat.sig62) state_next = S_DENORM;
      end
      S_DENORM: begin ctrl.op = OP_DENORM; state_next = S_FIN; end
      S_FIN: begin ctrl.op = OP_FIN; state_next = S_DONE; end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = state != S_IDLE;
  assign done = state == S_DONE;

endmodule

/* hdl/double_precision_float_alu_top.sv */
// channel   | transfer when       | ports
// ----------+---------------------+----------------------------------
// command   | start && !busy      | command, operand_a, operand_b
// result    | done (one cycle)    | result
//
// special operands (nan, inf, zero): result set in the check state, then done
// add/sub: align, add; a zero sum ends early, cancellation renormalises bit by bit
// multiply: four 32x32 partial products through one shared multiplier
// divide: one restoring quotient bit per cycle over 63 bits
// subnormal inputs are first normalised one bit at a time
// synchronous reset returns the controller to idle; the receiver cannot stall
module double_precision_float_alu_top
  import dpfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [63:0] operand_a,
  input  logic [63:0] operand_b,
  output logic        done,
  output logic [63:0] result
);

  // command and status between the controller and the datapath
  dp_ctrl_t ctrl;
  dp_stat_t stat;

  dpfa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy),
    .done  (done)
  );

  // operand unpacking, alignment, multiply, divide, rounding
  dpfa_datapath u_dp (
    .clk       (clk),
    .ctrl      (ctrl),
    .stat      (stat),
    .command   (command),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .result    (result)
  );

endmodule

/* hdl/dpfa_checker.sv */
module dpfa_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [63:0] result
);

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");
  a_take: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("transfer not taken");
  a_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done longer than one cycle");
  a_hold: assert property (@(posedge clk) disable iff (rst) (busy && !done) |=> busy)
    else $error("busy dropped without result");
  a_known: assert property (@(posedge clk) disable iff (rst) done |-> !$isunknown(result))
    else $error("result unknown");

endmodule

bind double_precision_float_alu_top dpfa_checker u_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
